@@ src/nlms_ec_pkg.sv @@
// Shared types and constants for the NLMS echo canceller.
package nlms_ec_pkg;

    typedef struct packed {
        logic signed [15:0] mic_sample;
        logic signed [15:0] ref_sample;
        logic               chunk_end;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] clean_sample;
        logic               chunk_end_out;
    } out_item_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int DELAY_W    = 13;
    localparam int Q15_W      = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING  = 2'd2;

    localparam logic [DELAY_W-1:0] DELAY_RESET  = 13'd320;
    localparam logic [Q15_W-1:0]   STEP_RESET   = 15'd4915;
    localparam logic [Q15_W-1:0]   SMOOTH_RESET = 15'd31130;

    localparam int EPS_Q30     = 107374;
    localparam int DT_BIAS_Q30 = 10737418;
    localparam int ONE_Q15     = 32768;

    // shared multiplier operand widths
    localparam int MUL_A_W = 44;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int ACC_W = 64;
    // step numerator: |mu*e| << 29
    localparam int NUM_W = 59;

endpackage

@@ src/nlms_ec_mul.sv @@
// Shared signed multiplier with registered product.
module nlms_ec_mul
    import nlms_ec_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] prod
);

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign prod = prod_reg;

endmodule

@@ src/nlms_ec_div.sv @@
// Restoring divider, one quotient bit per cycle.
module nlms_ec_div
    import nlms_ec_pkg::*;
#(
    parameter int DEN_W = 42
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ src/nlms_echo_canceller.sv @@
// When the weights adapt, an item takes a filter pass and an update pass over the tap
// memory, with a division by the one-bit-per-cycle divider between them; otherwise only
// the filter pass is made. The block returns to S_IDLE between items. One item at a
// time; a result not yet taken holds the next item back in S_DONE.
// After reset a clearing pass over all DELAY_LIMIT+TAPS ring entries zeroes the reference
// ring and weights; no item is taken meanwhile.
module nlms_echo_canceller
    import nlms_ec_pkg::*;
#(
    parameter int TAPS        = 512,
    parameter int DELAY_LIMIT = 4800
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int RING_LEN = DELAY_LIMIT + TAPS;
    localparam int RING_AW  = $clog2(RING_LEN);
    localparam int TAP_AW   = $clog2(TAPS);
    localparam int TAP_CW   = $clog2(TAPS + 1);
    localparam int EN_W     = 32 + $clog2(TAPS);
    localparam int DEN_W    = EN_W + 1;
    localparam int CALC_W   = ((RING_AW > DELAY_W) ? RING_AW : DELAY_W) + 1;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_FILT  = 9'b000000100,
        S_ERR   = 9'b000001000,
        S_POW   = 9'b000010000,
        S_CHECK = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_UPD   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg;

    logic [DELAY_W-1:0] delay_reg;
    logic [Q15_W-1:0]   step_reg;
    logic [Q15_W-1:0]   smooth_reg;

    logic [RING_AW-1:0] wp_reg;
    logic [RING_AW-1:0] clr_reg;
    logic [RING_AW-1:0] rd_ptr_reg;
    logic [RING_AW-1:0] rd_start_reg;
    logic [TAP_CW-1:0]  tap_cnt_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic [TAP_AW-1:0]  a1_reg;
    logic [TAP_AW-1:0]  a2_reg;
    logic [2:0]         pw_step_reg;
    logic               div_run_reg;
    logic               g_neg_reg;

    in_item_t                  item_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [EN_W-1:0]           energy_reg;
    logic [30:0]               sq_reg;
    logic signed [15:0]        e_reg;
    logic [31:0]               ref_pow_reg;
    logic [31:0]               mic_pow_reg;
    logic [47:0]               t_reg;
    logic signed [MUL_A_W-1:0] g_reg;
    logic signed [31:0]        wd2_reg;

    logic                      out_valid_reg;
    out_item_t                 out_reg;

    // memories
    logic signed [15:0] ring_mem [RING_LEN];
    logic signed [31:0] w_mem [TAPS];
    logic signed [15:0] ring_rdata_reg;
    logic signed [31:0] w_rdata_reg;

    logic               ring_we;
    logic [RING_AW-1:0] ring_waddr;
    logic signed [15:0] ring_wdata;
    logic               w_we;
    logic [TAP_AW-1:0]  w_waddr;
    logic signed [31:0] w_wdata;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;

    // divider
    logic             div_start;
    logic             div_done;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [NUM_W-1:0] div_quo;

    logic accept;
    logic issue;
    logic pass_busy;
    logic out_free;

    logic [CALC_W-1:0]       wp_ext;
    logic [CALC_W-1:0]       dl_ext;
    logic [CALC_W-1:0]       start_ext;
    logic [RING_AW-1:0]      rd_dec;
    logic signed [ACC_W-1:0] diff;
    logic signed [ACC_W-1:0] q_err;
    logic signed [15:0]      e_sat;
    logic [48:0]             pow_sum;
    logic                    adapt;
    logic [MUL_P_W-1:0]      mu_e_mag;
    logic signed [MUL_P_W-1:0] delta_rnd;
    logic signed [MUL_P_W-16:0] delta;
    logic signed [MUL_P_W-15:0] w_sum;
    logic signed [31:0]      w_sat;
    logic signed [MUL_B_W-1:0] one_minus_a;

    assign accept    = (state_reg == S_IDLE) && in_valid;
    assign in_ready  = (state_reg == S_IDLE);
    assign pass_busy = (state_reg == S_FILT) || (state_reg == S_UPD);
    assign issue     = pass_busy && (tap_cnt_reg < TAP_CW'(TAPS));
    assign out_free  = !out_valid_reg || out_ready;

    assign wp_ext    = CALC_W'(wp_reg);
    assign dl_ext    = CALC_W'(delay_reg);
    assign start_ext = (wp_ext >= dl_ext) ? (wp_ext - dl_ext)
                                          : (wp_ext + CALC_W'(RING_LEN) - dl_ext);
    assign rd_dec    = (rd_ptr_reg == '0) ? RING_AW'(RING_LEN - 1) : (rd_ptr_reg - 1'b1);

    // error: (mic << 29) - acc, divided by 2^29 toward zero, saturated
    assign diff  = (ACC_W'(item_reg.mic_sample) <<< 29) - acc_reg;
    assign q_err = (diff >>> 29) + $signed(ACC_W'((diff < 0) && (diff[28:0] != '0)));
    assign e_sat = (q_err > 32767)  ? 16'sh7fff :
                   (q_err < -32768) ? 16'sh8000 : q_err[15:0];

    assign one_minus_a = MUL_B_W'(ONE_Q15) - MUL_B_W'(smooth_reg);
    assign pow_sum     = 49'(t_reg) + 49'(prod[47:0]);

    assign adapt = (energy_reg > EN_W'(EPS_Q30)) &&
                   (35'(mic_pow_reg) < (35'(ref_pow_reg) << 2) + 35'(DT_BIAS_Q30));

    assign mu_e_mag = (prod < 0) ? MUL_P_W'(-prod) : MUL_P_W'(prod);
    assign div_num  = NUM_W'(mu_e_mag[29:0]) << 29;
    assign div_den  = DEN_W'(energy_reg) + DEN_W'(EPS_Q30);
    assign div_start = (state_reg == S_DIV) && !div_run_reg;

    // delta = g*x / 2^15 toward zero, then saturating weight add
    assign delta_rnd = prod + ((prod < 0) ? MUL_P_W'(32767) : MUL_P_W'(0));
    assign delta     = delta_rnd[MUL_P_W-1:15];
    assign w_sum     = (MUL_P_W-14)'(wd2_reg) + (MUL_P_W-14)'(delta);
    assign w_sat     = (w_sum > (MUL_P_W-14)'(32'sh7fffffff)) ? 32'sh7fffffff :
                       (w_sum < -(MUL_P_W-14)'(64'sh80000000)) ? 32'sh80000000 :
                       w_sum[31:0];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_FILT:
            begin
                mul_a = MUL_A_W'(w_rdata_reg);
                mul_b = MUL_B_W'(ring_rdata_reg);
            end
            S_UPD:
            begin
                mul_a = g_reg;
                mul_b = MUL_B_W'(ring_rdata_reg);
            end
            S_POW:
            begin
                case (pw_step_reg)
                    3'd0:
                    begin
                        mul_a = MUL_A_W'(item_reg.ref_sample);
                        mul_b = MUL_B_W'(item_reg.ref_sample);
                    end
                    3'd1, 3'd4:
                    begin
                        mul_a = MUL_A_W'({1'b0, prod[30:0]});
                        mul_b = one_minus_a;
                    end
                    3'd2:
                    begin
                        mul_a = MUL_A_W'({1'b0, ref_pow_reg});
                        mul_b = MUL_B_W'({1'b0, smooth_reg});
                    end
                    3'd3:
                    begin
                        mul_a = MUL_A_W'(item_reg.mic_sample);
                        mul_b = MUL_B_W'(item_reg.mic_sample);
                    end
                    3'd5:
                    begin
                        mul_a = MUL_A_W'({1'b0, mic_pow_reg});
                        mul_b = MUL_B_W'({1'b0, smooth_reg});
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_CHECK:
            begin
                mul_a = MUL_A_W'({1'b0, step_reg});
                mul_b = MUL_B_W'(e_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        ring_we    = 1'b0;
        ring_waddr = wp_reg;
        ring_wdata = in_data.ref_sample;
        w_we       = 1'b0;
        w_waddr    = a2_reg;
        w_wdata    = w_sat;
        if (state_reg == S_CLEAR)
        begin
            ring_we    = 1'b1;
            ring_waddr = clr_reg;
            ring_wdata = '0;
            w_we       = 32'(clr_reg) < TAPS;
            w_waddr    = clr_reg[TAP_AW-1:0];
            w_wdata    = '0;
        end
        else if (accept)
        begin
            ring_we = 1'b1;
        end
        else if ((state_reg == S_UPD) && v2_reg)
        begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        ring_rdata_reg <= ring_mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            w_mem[w_waddr] <= w_wdata;
        end
        w_rdata_reg <= w_mem[tap_cnt_reg[TAP_AW-1:0]];
    end

    nlms_ec_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    nlms_ec_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg  <= DELAY_RESET;
            step_reg   <= STEP_RESET;
            smooth_reg <= SMOOTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ECHO_DELAY:
                begin
                    if (32'(cfg_data) < DELAY_LIMIT)
                    begin
                        delay_reg <= cfg_data[DELAY_W-1:0];
                    end
                end
                CFG_STEP_SIZE: step_reg <= cfg_data;
                CFG_SMOOTHING: smooth_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            wp_reg        <= '0;
            rd_ptr_reg    <= '0;
            rd_start_reg  <= '0;
            tap_cnt_reg   <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            a1_reg        <= '0;
            a2_reg        <= '0;
            pw_step_reg   <= '0;
            div_run_reg   <= 1'b0;
            g_neg_reg     <= 1'b0;
            ref_pow_reg   <= '0;
            mic_pow_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // in S_DONE a taken result is replaced by the next one below
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            if (issue)
            begin
                rd_ptr_reg  <= rd_dec;
                tap_cnt_reg <= tap_cnt_reg + 1'b1;
                a1_reg      <= tap_cnt_reg[TAP_AW-1:0];
            end
            v1_reg <= issue;
            v2_reg <= v1_reg && pass_busy;
            if (v1_reg)
            begin
                a2_reg  <= a1_reg;
                wd2_reg <= w_rdata_reg;
                sq_reg  <= 31'(32'(ring_rdata_reg) * 32'(ring_rdata_reg));
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == RING_AW'(RING_LEN - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg     <= in_data;
                        rd_ptr_reg   <= start_ext[RING_AW-1:0];
                        rd_start_reg <= start_ext[RING_AW-1:0];
                        tap_cnt_reg  <= '0;
                        acc_reg      <= '0;
                        energy_reg   <= '0;
                        state_reg    <= S_FILT;
                    end
                end
                S_FILT:
                begin
                    if (v2_reg)
                    begin
                        acc_reg    <= acc_reg + ACC_W'(prod);
                        energy_reg <= energy_reg + EN_W'(sq_reg);
                    end
                    if (!issue && !v1_reg && !v2_reg)
                    begin
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    e_reg       <= e_sat;
                    pw_step_reg <= '0;
                    state_reg   <= S_POW;
                end
                S_POW:
                begin
                    pw_step_reg <= pw_step_reg + 1'b1;
                    case (pw_step_reg)
                        3'd2, 3'd5: t_reg <= prod[47:0];
                        3'd3: ref_pow_reg <= pow_sum[46:15];
                        3'd6:
                        begin
                            mic_pow_reg <= pow_sum[46:15];
                            state_reg   <= S_CHECK;
                        end
                        default: ;
                    endcase
                end
                S_CHECK:
                begin
                    div_run_reg <= 1'b0;
                    state_reg   <= adapt ? S_DIV : S_DONE;
                end
                S_DIV:
                begin
                    if (!div_run_reg)
                    begin
                        div_run_reg <= 1'b1;
                        g_neg_reg   <= prod < 0;
                    end
                    else if (div_done)
                    begin
                        g_reg <= g_neg_reg ? -MUL_A_W'(div_quo[MUL_A_W-2:0])
                                           : MUL_A_W'(div_quo[MUL_A_W-2:0]);
                        rd_ptr_reg  <= rd_start_reg;
                        tap_cnt_reg <= '0;
                        state_reg   <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    if (!issue && !v1_reg && !v2_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg         <= 1'b1;
                        out_reg.clean_sample  <= e_reg;
                        out_reg.chunk_end_out <= item_reg.chunk_end;
                        wp_reg    <= (wp_reg == RING_AW'(RING_LEN - 1)) ? '0 : wp_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
